### rtl/core/set_assoc_lru_cache_assert.svh
// ----------------------------------------------------------------------------
// set_assoc_lru_cache assertion macros
// shared assertion shorthands, sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_ASSERT_SVH

// same-cycle implication
`define SAC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared constants, types and helpers of the set associative lru cache
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned BYTE_OFS_W = 2;

  localparam int unsigned SETS_DEF            = 64;
  localparam int unsigned WAYS_DEF            = 4;
  localparam int unsigned WORDS_PER_BLOCK_DEF = 8;

  // derived defaults for the submodules
  localparam int unsigned WAY_W_DEF = 2;
  localparam int unsigned TAG_W_DEF = 21;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  // one access leaving the lookup stage
  typedef struct packed {
    logic fire;
    logic is_write;
    logic hit;
  } acc_evt_t;

  // floor of log2, zero for values up to one
  function automatic int unsigned flog2(input int unsigned v);
    int unsigned b;
    int unsigned x;
    b = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      b = b + 1;
    end
    return b;
  endfunction

endpackage

### rtl/core/sac_channels_if.sv
// ----------------------------------------------------------------------------
// sac channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sac_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [sac_pkg::ADDR_W-1:0]  addr;
  logic [sac_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, mode, addr, write_data, input ready);
  modport sink   (input valid, mode, addr, write_data, output ready);
endinterface

interface sac_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [sac_pkg::DATA_W-1:0] read_data;
  logic [sac_pkg::CNT_W-1:0]  read_hits;
  logic [sac_pkg::CNT_W-1:0]  read_misses;
  logic [sac_pkg::CNT_W-1:0]  write_hits;
  logic [sac_pkg::CNT_W-1:0]  write_misses;

  modport source (output valid, hit, read_data, read_hits, read_misses, write_hits,
                  write_misses, input ready);
  modport sink   (input valid, hit, read_data, read_hits, read_misses, write_hits,
                  write_misses, output ready);
endinterface

### rtl/core/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sac_lookup.sv
// ----------------------------------------------------------------------------
// sac_lookup
// tag compare, victim pick, lru rank update and word select for one set
// ----------------------------------------------------------------------------
module sac_lookup #(
  parameter int unsigned WAYS   = sac_pkg::WAYS_DEF,
  parameter int unsigned WAY_W  = sac_pkg::WAY_W_DEF,
  parameter int unsigned TAG_W  = sac_pkg::TAG_W_DEF,
  parameter int unsigned DATA_W = sac_pkg::DATA_W
) (
  input  logic                          is_write_i,
  input  logic [TAG_W-1:0]              req_tag_i,
  input  logic [DATA_W-1:0]             wdata_i,
  input  logic [WAYS-1:0]               valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]    tag_i,
  input  logic [WAYS-1:0][WAY_W-1:0]    rank_i,
  input  logic [WAYS-1:0][DATA_W-1:0]   data_i,
  output logic                          hit_o,
  output logic [WAYS-1:0]               match_o,
  output logic [WAY_W-1:0]              way_o,
  output logic [DATA_W-1:0]             rdata_o,
  output logic [WAYS-1:0]               valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]    tag_o,
  output logic [WAYS-1:0][WAY_W-1:0]    rank_o,
  output logic [WAYS-1:0][DATA_W-1:0]   data_o
);

  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way;
  logic [WAY_W-1:0] old_rank;

  always_comb begin
    hit_way = '0;
    victim  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_i[w] && (tag_i[w] == req_tag_i);
    end
    // descending scan leaves the lowest way
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (rank_i[w] == '0) begin
        victim = WAY_W'(w);
      end
    end
  end

  assign hit_o    = |match;
  assign match_o  = match;
  assign way      = hit_o ? hit_way : victim;
  assign way_o    = way;
  assign old_rank = rank_i[way];

  always_comb begin
    valid_o = valid_i;
    tag_o   = tag_i;
    data_o  = data_i;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        rank_o[w] = WAY_W'(WAYS - 1);
      end else if (rank_i[w] > old_rank) begin
        rank_o[w] = rank_i[w] - 1'b1;
      end else begin
        rank_o[w] = rank_i[w];
      end
    end
    valid_o[way] = 1'b1;
    if (!hit_o) begin
      tag_o[way] = req_tag_i;
    end
    if (is_write_i) begin
      data_o[way] = wdata_i;
    end
  end

  assign rdata_o = is_write_i ? '0 : data_i[way];

endmodule

### rtl/core/sac_stats.sv
// ----------------------------------------------------------------------------
// sac_stats
// wrapping hit and miss counters for reads and writes
// ----------------------------------------------------------------------------
module sac_stats (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sac_pkg::acc_evt_t         evt_i,
  output logic [sac_pkg::CNT_W-1:0] read_hits_o,
  output logic [sac_pkg::CNT_W-1:0] read_misses_o,
  output logic [sac_pkg::CNT_W-1:0] write_hits_o,
  output logic [sac_pkg::CNT_W-1:0] write_misses_o
);
  import sac_pkg::*;

  logic [CNT_W-1:0] rd_hit_q, rd_miss_q, wr_hit_q, wr_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q  <= '0;
      rd_miss_q <= '0;
      wr_hit_q  <= '0;
      wr_miss_q <= '0;
    end else if (evt_i.fire) begin
      if (evt_i.is_write) begin
        if (evt_i.hit) wr_hit_q  <= wr_hit_q + 1'b1;
        else           wr_miss_q <= wr_miss_q + 1'b1;
      end else begin
        if (evt_i.hit) rd_hit_q  <= rd_hit_q + 1'b1;
        else           rd_miss_q <= rd_miss_q + 1'b1;
      end
    end
  end

  assign read_hits_o    = rd_hit_q;
  assign read_misses_o  = rd_miss_q;
  assign write_hits_o   = wr_hit_q;
  assign write_misses_o = wr_miss_q;

endmodule

### rtl/core/set_assoc_lru_cache.sv
// an accepted beat reads both rams into stage 1; lookup and set update run there together
// throughput: one beat per cycle unless the response side stalls
// reset: counters and handshake state clear at once, then a ram clearing pass over the
// SETS*WORDS_PER_BLOCK rows (power-of-two part) runs before the first beat is taken
// ----------------------------------------------------------------------------
// set_assoc_lru_cache
// set associative word cache with true lru replacement and hit/miss counters
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_assert.svh"

module set_assoc_lru_cache #(
  parameter int unsigned SETS            = sac_pkg::SETS_DEF,
  parameter int unsigned WAYS            = sac_pkg::WAYS_DEF,
  parameter int unsigned WORDS_PER_BLOCK = sac_pkg::WORDS_PER_BLOCK_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sac_req_if.sink     req_i,
  sac_rsp_if.source   rsp_o
);
  import sac_pkg::*;

  // address split: | tag | set | word | byte |
  localparam int unsigned IDX_W     = flog2(SETS);
  localparam int unsigned OFS_W     = flog2(WORDS_PER_BLOCK);
  localparam int unsigned TAG_W     = ADDR_W - IDX_W - OFS_W - BYTE_OFS_W;
  localparam int unsigned SET_AW    = (IDX_W > 0) ? IDX_W : 1;
  localparam int unsigned ROW_BITS  = IDX_W + OFS_W;
  localparam int unsigned ROW_AW    = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int unsigned SET_DEPTH = 1 << IDX_W;
  localparam int unsigned ROW_DEPTH = 1 << ROW_BITS;
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W    = WAYS * (1 + TAG_W + WAY_W);
  localparam int unsigned DROW_W    = WAYS * DATA_W;
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((1 << IDX_W) - 1);
  localparam logic [ADDR_W-1:0] ROW_MASK = ADDR_W'((1 << ROW_BITS) - 1);

  // ---------------------------------------------------------------------------
  // reset clearing pass over both rams
  // ---------------------------------------------------------------------------
  logic              clearing_q;
  logic [ROW_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == ROW_AW'(ROW_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic accept;

  // stage 1 moves on when the response register is free or being drained
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request decode and stage 1 payload
  // ---------------------------------------------------------------------------
  logic [SET_AW-1:0] req_set;
  logic [ROW_AW-1:0] req_row;
  logic [TAG_W-1:0]  req_tag;

  // row address is the set and word fields taken together
  assign req_set = SET_AW'((req_i.addr >> (BYTE_OFS_W + OFS_W)) & SET_MASK);
  assign req_row = ROW_AW'((req_i.addr >> BYTE_OFS_W) & ROW_MASK);
  assign req_tag = TAG_W'(req_i.addr >> (BYTE_OFS_W + OFS_W + IDX_W));

  logic              s1_write_q;
  logic [DATA_W-1:0] s1_wdata_q;
  logic [TAG_W-1:0]  s1_tag_q;
  logic [SET_AW-1:0] s1_set_q;
  logic [ROW_AW-1:0] s1_row_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q <= (req_i.mode == MODE_WRITE);
      s1_wdata_q <= req_i.write_data;
      s1_tag_q   <= req_tag;
      s1_set_q   <= req_set;
      s1_row_q   <= req_row;
    end
  end

  // ---------------------------------------------------------------------------
  // storage: one metadata row per set (valid, tags, ranks of all ways) and
  // one data row per set and word (that word of every way)
  // ---------------------------------------------------------------------------
  logic [META_W-1:0] meta_rdata, meta_cur, meta_new, meta_wdata;
  logic [DROW_W-1:0] data_rdata, data_cur, data_new, data_wdata;
  logic [SET_AW-1:0] meta_waddr;
  logic [ROW_AW-1:0] data_waddr;
  logic              ram_we;

  assign ram_we     = clearing_q || s1_adv;
  assign meta_waddr = clearing_q ? clr_cnt_q[SET_AW-1:0] : s1_set_q;
  assign data_waddr = clearing_q ? clr_cnt_q : s1_row_q;
  assign meta_wdata = clearing_q ? '0 : meta_new;
  assign data_wdata = clearing_q ? '0 : data_new;

  sac_ram #(
    .WIDTH (META_W),
    .DEPTH (SET_DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (req_set),
    .rdata_o (meta_rdata)
  );

  sac_ram #(
    .WIDTH (DROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (accept),
    .raddr_i (req_row),
    .rdata_o (data_rdata)
  );

  // ---------------------------------------------------------------------------
  // bypass of the last update: a row read at the edge of its own write
  // returns the old contents, so the most recent write stands in for it
  // ---------------------------------------------------------------------------
  logic              fwd_valid_q;
  logic [SET_AW-1:0] fwd_set_q;
  logic [ROW_AW-1:0] fwd_row_q;
  logic [META_W-1:0] fwd_meta_q;
  logic [DROW_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_set_q  <= s1_set_q;
      fwd_row_q  <= s1_row_q;
      fwd_meta_q <= meta_new;
      fwd_data_q <= data_new;
    end
  end

  assign meta_cur = (fwd_valid_q && fwd_set_q == s1_set_q) ? fwd_meta_q : meta_rdata;
  assign data_cur = (fwd_valid_q && fwd_row_q == s1_row_q) ? fwd_data_q : data_rdata;

  // ---------------------------------------------------------------------------
  // lookup and set update
  // ---------------------------------------------------------------------------
  logic [WAYS-1:0]              cur_valid, new_valid;
  logic [WAYS-1:0][TAG_W-1:0]   cur_tag, new_tag;
  logic [WAYS-1:0][WAY_W-1:0]   cur_rank, new_rank;
  logic [WAYS-1:0][DATA_W-1:0]  cur_data, new_data;
  logic                         lk_hit;
  logic [WAYS-1:0]              lk_match;
  logic [WAY_W-1:0]             lk_way;
  logic [DATA_W-1:0]            lk_rdata;

  assign {cur_rank, cur_tag, cur_valid} = meta_cur;
  assign cur_data = data_cur;
  assign meta_new = {new_rank, new_tag, new_valid};
  assign data_new = new_data;

  sac_lookup #(
    .WAYS   (WAYS),
    .WAY_W  (WAY_W),
    .TAG_W  (TAG_W),
    .DATA_W (DATA_W)
  ) u_lookup (
    .is_write_i (s1_write_q),
    .req_tag_i  (s1_tag_q),
    .wdata_i    (s1_wdata_q),
    .valid_i    (cur_valid),
    .tag_i      (cur_tag),
    .rank_i     (cur_rank),
    .data_i     (cur_data),
    .hit_o      (lk_hit),
    .match_o    (lk_match),
    .way_o      (lk_way),
    .rdata_o    (lk_rdata),
    .valid_o    (new_valid),
    .tag_o      (new_tag),
    .rank_o     (new_rank),
    .data_o     (new_data)
  );

  // ---------------------------------------------------------------------------
  // counters and response register
  // ---------------------------------------------------------------------------
  acc_evt_t evt;

  assign evt.fire     = s1_adv;
  assign evt.is_write = s1_write_q;
  assign evt.hit      = lk_hit;

  // counters only move when the response register loads, so they pair with it
  sac_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt),
    .read_hits_o    (rsp_o.read_hits),
    .read_misses_o  (rsp_o.read_misses),
    .write_hits_o   (rsp_o.write_hits),
    .write_misses_o (rsp_o.write_misses)
  );

  logic              out_hit_q;
  logic [DATA_W-1:0] out_rdata_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_hit_q   <= lk_hit;
      out_rdata_q <= lk_rdata;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.read_data = out_rdata_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SAC_ASSERT_IMP(a_tag_unique, s1_adv, $onehot0(lk_match),
                  "two valid ways of a set hold the same tag")
  `SAC_ASSERT_IMP(a_touched_top, s1_adv, new_rank[lk_way] == WAY_W'(WAYS - 1),
                  "touched way did not become most recent")
  `SAC_ASSERT_IMP(a_valid_keep, s1_adv, (new_valid & cur_valid) == cur_valid,
                  "a valid way was dropped by an update")
  `SAC_ASSERT_NXT(a_rsp_load, s1_adv, rsp_o.valid,
                  "lookup result did not reach the response register")

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the set associative lru word cache: a shadow copy
// of tags, valid bits, lru ranks, data words and counters predicts every
// response; requests come in random bursts, the response side stalls on its
// own pattern and once holds off long enough to back the cache up
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sac_pkg::*;

  localparam int unsigned SETS     = SETS_DEF;
  localparam int unsigned WAYS     = WAYS_DEF;
  localparam int unsigned WPB      = WORDS_PER_BLOCK_DEF;
  localparam int unsigned IB       = $clog2(SETS);
  localparam int unsigned BB       = $clog2(WPB);
  localparam int unsigned TAG_W    = ADDR_W - IB - BB - BYTE_OFS_W;
  localparam int unsigned RSP_LAT  = 2;
  localparam int unsigned N_RANDOM = 450;
  localparam int unsigned HOLD_CYC = 80;
  localparam int unsigned IDLE_MAX = 4000;
  localparam int unsigned MAX_SHOWN = 10;

  // one expected or observed response beat
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  read_hits;
    logic [CNT_W-1:0]  read_misses;
    logic [CNT_W-1:0]  write_hits;
    logic [CNT_W-1:0]  write_misses;
  } cache_rsp_t;

  // styles of the response-side stall pattern
  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_LIGHT  = 2'd1,
    RX_HEAVY  = 2'd2,
    RX_PERIOD = 2'd3
  } rx_style_e;

  // shadow of the cache contents and the queue of responses still owed
  class cache_shadow;
    bit [TAG_W-1:0]  tag_mem  [SETS][WAYS];
    bit              vld      [SETS][WAYS];
    bit [1:0]        rank     [SETS][WAYS];
    bit [DATA_W-1:0] word_mem [SETS][WAYS][WPB];
    bit [CNT_W-1:0]  rd_hits, rd_miss, wr_hits, wr_miss;
    cache_rsp_t      rsp_due_q [$];
    int unsigned     n_taken;
    int unsigned     n_errors;

    function void flag(string msg);
      n_errors++;
      if (n_errors <= MAX_SHOWN) $display("%0t ERROR %s", $realtime, msg);
    endfunction

    // note an accepted request beat and predict its response
    function void take_access(mode_e m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      cache_rsp_t     r;
      int unsigned    set, wrd, way, old;
      bit [TAG_W-1:0] tg;
      bit             found;
      wrd   = a[BYTE_OFS_W +: BB];
      set   = a[BYTE_OFS_W + BB +: IB];
      tg    = a[ADDR_W-1 -: TAG_W];
      found = 1'b0;
      way   = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (vld[set][w] && tag_mem[set][w] == tg) begin
          found = 1'b1;
          way   = w;
          break;
        end
      end
      if (!found) begin
        // victim: lowest way holding rank zero
        for (int w = 0; w < WAYS; w++) begin
          if (rank[set][w] == 0) begin
            way = w;
            break;
          end
        end
        tag_mem[set][way] = tg;
        vld[set][way]     = 1'b1;
      end
      r     = '0;
      r.hit = found;
      if (m == MODE_WRITE) begin
        word_mem[set][way][wrd] = d;
        if (found) wr_hits++;
        else wr_miss++;
      end else begin
        r.read_data = word_mem[set][way][wrd];
        if (found) rd_hits++;
        else rd_miss++;
      end
      old = rank[set][way];
      for (int w = 0; w < WAYS; w++) begin
        if (rank[set][w] > old) rank[set][w]--;
      end
      rank[set][way] = 2'(WAYS - 1);
      r.read_hits    = rd_hits;
      r.read_misses  = rd_miss;
      r.write_hits   = wr_hits;
      r.write_misses = wr_miss;
      rsp_due_q.push_back(r);
      n_taken++;
    endfunction

    // compare one accepted response beat with the oldest prediction
    function void check_response(cache_rsp_t act);
      cache_rsp_t exp;
      if (rsp_due_q.size() == 0) begin
        flag("response beat with no request outstanding");
        return;
      end
      exp = rsp_due_q.pop_front();
      if (exp.hit != act.hit)
        flag($sformatf("hit exp %0d act %0d", exp.hit, act.hit));
      if (exp.read_data != act.read_data)
        flag($sformatf("read_data exp %h act %h", exp.read_data, act.read_data));
      if (exp.read_hits != act.read_hits)
        flag($sformatf("read_hits exp %0d act %0d", exp.read_hits, act.read_hits));
      if (exp.read_misses != act.read_misses)
        flag($sformatf("read_misses exp %0d act %0d", exp.read_misses, act.read_misses));
      if (exp.write_hits != act.write_hits)
        flag($sformatf("write_hits exp %0d act %0d", exp.write_hits, act.write_hits));
      if (exp.write_misses != act.write_misses)
        flag($sformatf("write_misses exp %0d act %0d", exp.write_misses, act.write_misses));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sac_req_if req_if ();
  sac_rsp_if rsp_if ();

  set_assoc_lru_cache dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cache_shadow shadow = new();

  // sender burst state
  int unsigned burst_left = 0;

  // address pools: a few hot sets and more tags than ways so lines get evicted
  logic [TAG_W-1:0] tag_pool [8];
  logic [IB-1:0]    set_pool [4];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] mk_addr(logic [TAG_W-1:0] tg, logic [IB-1:0] set,
                                                logic [BB-1:0] wrd, logic [1:0] bo);
    return {tg, set, wrd, bo};
  endfunction

  // mostly hot-pool addresses, the rest fully random
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 8)
      return mk_addr(tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 3)],
                     BB'($urandom_range(0, WPB - 1)), 2'($urandom_range(0, 3)));
    return $urandom();
  endfunction

  // offer one request beat, wait for it to be taken, then maybe pause
  task automatic send_access(mode_e m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.mode       <= m;
    req_if.addr       <= a;
    req_if.write_data <= d;
    do @(posedge clk_i); while (!req_if.ready);
    shadow.take_access(m, a, d);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // new burst; a long one now and then gives stretches with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // response monitor, sampled at the edge before any update lands
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      shadow.check_response('{rsp_if.hit, rsp_if.read_data, rsp_if.read_hits,
                              rsp_if.read_misses, rsp_if.write_hits, rsp_if.write_misses});
  end

  // receiver: stall style rotates through the four styles, one long hold-off mid run
  initial begin
    int unsigned cyc;
    rx_style_e   style;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && shadow.n_taken >= 150) begin
        // sender keeps offering while we sit on our hands, so the cache backs up
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end
      style = rx_style_e'((cyc / 64) % 4);
      case (style)
        RX_OPEN:   rsp_if.ready <= 1'b1;
        RX_LIGHT:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  rsp_if.ready <= ($urandom_range(0, 9) < 4);
        RX_PERIOD: rsp_if.ready <= (cyc % 5 != 0);
        default:   rsp_if.ready <= 1'b1;
      endcase
      cyc++;
    end
  end

  // watchdog: cycles with no beat on either channel; covers the clearing pass
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // main stimulus
  initial begin
    logic [ADDR_W-1:0] a;
    mode_e             m;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_READ;
    req_if.addr       <= '0;
    req_if.write_data <= '0;
    rst_ni            <= 1'b0;

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_W'($urandom());
    set_pool[0] = '0;
    set_pool[1] = '1;
    set_pool[2] = IB'($urandom());
    set_pool[3] = IB'($urandom());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared tag zero must not hit; the read miss fills the line, so the write after it hits
    send_access(MODE_READ,  32'h0000_0000, 32'h1234_5678);
    send_access(MODE_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    // byte offset bits are don't-care
    send_access(MODE_READ,  32'h0000_0003, 32'h0);
    send_access(MODE_READ,  mk_addr('0, 6'd2, 3'd5, 2'd1), 32'h0);
    // top of the address space: last set, last word, all-ones tag
    send_access(MODE_WRITE, 32'hFFFF_FFFC, 32'hA5A5_A5A5);
    send_access(MODE_READ,  32'hFFFF_FFFF, 32'h0);
    send_access(MODE_WRITE, 32'hFFFF_FFF8, 32'h0000_0000);
    // fill all ways of set 1 in order, invalid ways go first
    for (int t = 1; t <= 4; t++)
      send_access(MODE_WRITE, mk_addr(TAG_W'(t), 6'd1, 3'd3, 2'd0), 32'hC0DE_0000 + t);
    // make tag 1 most recent, then a write miss evicts tag 2
    send_access(MODE_READ,  mk_addr(21'd1, 6'd1, 3'd3, 2'd2), 32'h0);
    send_access(MODE_WRITE, mk_addr(21'd5, 6'd1, 3'd7, 2'd0), 32'h5555_AAAA);
    // read miss on tag 2 takes tag 3's line and returns its stale word
    send_access(MODE_READ,  mk_addr(21'd2, 6'd1, 3'd3, 2'd0), 32'h0);
    send_access(MODE_READ,  mk_addr(21'd5, 6'd1, 3'd7, 2'd3), 32'h0);
    send_access(MODE_READ,  mk_addr(21'd3, 6'd1, 3'd3, 2'd0), 32'h0);
    send_access(MODE_WRITE, mk_addr(21'd4, 6'd1, 3'd0, 2'd0), 32'h8000_0001);
    send_access(MODE_READ,  mk_addr(21'd4, 6'd1, 3'd0, 2'd0), 32'h0);
    send_access(MODE_READ,  32'h5555_5555, 32'h0);
    send_access(MODE_WRITE, 32'hAAAA_AAAA, 32'h5A5A_5A5A);

    // random part, back-to-back beats to the same set exercise forwarding
    for (int i = 0; i < N_RANDOM; i++) begin
      a = pick_addr();
      m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
      send_access(m, a, $urandom());
    end
    req_if.valid <= 1'b0;

    while (shadow.rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (RSP_LAT + 8) @(posedge clk_i);

    if (shadow.n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sac_pkg.sv
rtl/core/sac_channels_if.sv
rtl/core/sac_ram.sv
rtl/core/sac_lookup.sv
rtl/core/sac_stats.sv
rtl/core/set_assoc_lru_cache.sv
sim/tb.sv
